FILE: rtl/euler_lead_lag_filter_macros.svh
// Assertion macros for the Euler lead-lag filter.
// Used by euler_lead_lag_filter.sv; expects clk and rst_n in scope.
`ifndef EULER_LEAD_LAG_FILTER_MACROS_SVH
`define EULER_LEAD_LAG_FILTER_MACROS_SVH

// implication checked in the next cycle
`define ELLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication
`define ELLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ellf_pkg.sv
// Package for the Euler lead-lag filter: payload types, register indexes,
// microcode encoding and the control store. No dependencies.
package ellf_pkg;

  localparam int DATA_W = 32;
  localparam int PC_W   = 5;

  typedef struct packed {
    logic              op;
    logic signed [31:0] sample_in;
    logic signed [31:0] limit_low;
    logic signed [31:0] limit_high;
  } in_t;

  typedef struct packed {
    logic signed [31:0] filter_out;
    logic               saturated;
  } out_t;

  // config register indexes
  localparam logic [2:0] REG_FILTER_MODE     = 3'd0;
  localparam logic [2:0] REG_GAIN_ZERO       = 3'd1;
  localparam logic [2:0] REG_GAIN_ONE        = 3'd2;
  localparam logic [2:0] REG_POLE_ZERO       = 3'd3;
  localparam logic [2:0] REG_POLE_ONE_RECIP  = 3'd4;
  localparam logic [2:0] REG_TIME_STEP       = 3'd5;
  localparam logic [2:0] REG_TIME_STEP_RECIP = 3'd6;

  localparam logic [1:0] MODE_LAG      = 2'd0;
  localparam logic [1:0] MODE_LEAD_LAG = 2'd1;

  localparam logic op_clamp = 1'b1;

  // micro-ops
  localparam logic [3:0] UOP_NOP   = 4'd0;
  localparam logic [3:0] UOP_DISP  = 4'd1;  // multiway dispatch on item kind
  localparam logic [3:0] UOP_MUL   = 4'd2;  // prod = a * b per mul pair
  localparam logic [3:0] UOP_ADDY  = 4'd3;  // y = sat(y + q)
  localparam logic [3:0] UOP_MOVT  = 4'd4;  // t = q
  localparam logic [3:0] UOP_SUBA  = 4'd5;  // acc = sat(t - q)
  localparam logic [3:0] UOP_SUBR  = 4'd6;  // t = sat(r - prev)
  localparam logic [3:0] UOP_ADDA  = 4'd7;  // acc = sat(acc + q)
  localparam logic [3:0] UOP_PREV  = 4'd8;  // prev = r
  localparam logic [3:0] UOP_SLOPE = 4'd9;  // slope = q, started = 1
  localparam logic [3:0] UOP_CLAMP = 4'd10;
  localparam logic [3:0] UOP_OUT   = 4'd11;

  // multiplier operand pairs
  localparam logic [2:0] MP_SLOPE_DT = 3'd0;
  localparam logic [2:0] MP_A0_R     = 3'd1;
  localparam logic [2:0] MP_B0_Y     = 3'd2;
  localparam logic [2:0] MP_T_DTR    = 3'd3;
  localparam logic [2:0] MP_A1_T     = 3'd4;
  localparam logic [2:0] MP_ACC_B1R  = 3'd5;

  // branch conditions
  localparam logic [1:0] BR_NONE        = 2'd0;
  localparam logic [1:0] BR_ALWAYS      = 2'd1;
  localparam logic [1:0] BR_MODE_LAG    = 2'd2;
  localparam logic [1:0] BR_NOT_STARTED = 2'd3;

  // program labels
  localparam logic [PC_W-1:0] L_DISP    = 5'd0;
  localparam logic [PC_W-1:0] L_INTEG   = 5'd1;
  localparam logic [PC_W-1:0] L_SLOPE_A = 5'd3;
  localparam logic [PC_W-1:0] L_PREV    = 5'd13;
  localparam logic [PC_W-1:0] L_FIN     = 5'd14;
  localparam logic [PC_W-1:0] L_CLAMP   = 5'd16;
  localparam logic [PC_W-1:0] L_OUT     = 5'd17;

  typedef struct packed {
    logic [3:0]      uop;
    logic [2:0]      mp;
    logic [1:0]      br;
    logic [PC_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } sat_res_t;

  // clip a 33-bit sum to 32 bits
  function automatic sat_res_t sat33(input logic signed [32:0] s);
    sat_res_t res;
    res.sat = s[32] ^ s[31];
    if (!res.sat) begin
      res.val = s[31:0];
    end else if (s[32]) begin
      res.val = {1'b1, {31{1'b0}}};
    end else begin
      res.val = {1'b0, {31{1'b1}}};
    end
    return res;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{uop: UOP_NOP, mp: MP_SLOPE_DT, br: BR_NONE, tgt: L_DISP};
    unique case (pc)
      5'd0:  c.uop = UOP_DISP;
      5'd1:  begin c.uop = UOP_MUL; c.mp = MP_SLOPE_DT; end
      5'd2:  c.uop = UOP_ADDY;
      5'd3:  begin c.uop = UOP_MUL; c.mp = MP_A0_R; end
      5'd4:  c.uop = UOP_MOVT;
      5'd5:  begin c.uop = UOP_MUL; c.mp = MP_B0_Y; end
      5'd6:  begin c.uop = UOP_SUBA; c.br = BR_MODE_LAG; c.tgt = L_FIN; end
      5'd7:  begin c.uop = UOP_NOP; c.br = BR_NOT_STARTED; c.tgt = L_PREV; end
      5'd8:  c.uop = UOP_SUBR;
      5'd9:  begin c.uop = UOP_MUL; c.mp = MP_T_DTR; end
      5'd10: c.uop = UOP_MOVT;
      5'd11: begin c.uop = UOP_MUL; c.mp = MP_A1_T; end
      5'd12: c.uop = UOP_ADDA;
      5'd13: c.uop = UOP_PREV;
      5'd14: begin c.uop = UOP_MUL; c.mp = MP_ACC_B1R; end
      5'd15: begin c.uop = UOP_SLOPE; c.br = BR_ALWAYS; c.tgt = L_OUT; end
      5'd16: c.uop = UOP_CLAMP;
      5'd17: c.uop = UOP_OUT;
      default: begin c.uop = UOP_NOP; c.br = BR_ALWAYS; c.tgt = L_OUT; end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/euler_lead_lag_filter.sv
// Each request runs a microprogram for clamp, unsupported mode, lag or lead-lag,
// with a shorter path for the first sample; at most one multiply or one
// saturating add per step.
// One request in flight: the next is taken while a result waits in out_data, and a
// stalled result holds the sequencer.
// Reset (synchronous, rst_n low) clears filter state and loads register defaults.
`include "euler_lead_lag_filter_macros.svh"

module euler_lead_lag_filter
  import ellf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PROD_W = 2 * (DATA_W + 1);

  // configuration
  logic [1:0]         mode_r;
  logic signed [31:0] a0_r, a1_r, b0_r, b1r_r;
  logic [16:0]        dt_r;
  logic [30:0]        dtr_r;

  // sequencer and datapath
  logic               busy_r;
  logic [PC_W-1:0]    pc_r;
  logic               out_valid_r;
  out_t               out_r;
  in_t                req_r;
  logic               show_y_r;
  logic               sat_r;
  logic               started_r;
  logic signed [31:0] y_r, slope_r, prev_r, t_r, acc_r;
  logic signed [PROD_W-1:0] prod_r;

  ctrl_t              cw;
  logic signed [32:0] ma, mb;
  logic signed [PROD_W-1:0] q_sh;
  logic               q_ovf;
  logic signed [31:0] q_val;
  sat_res_t           sum_res;
  logic signed [31:0] clamp_lo;
  logic               br_take;
  logic [PC_W-1:0]    pc_seq;
  logic [PC_W-1:0]    pc_nxt;
  logic               out_hold;
  logic               out_load;

  assign cw = ucode(pc_r);

  always_comb begin
    unique case (cw.mp)
      MP_SLOPE_DT: begin ma = {slope_r[31], slope_r}; mb = {16'b0, dt_r}; end
      MP_A0_R:     begin ma = {a0_r[31], a0_r}; mb = {req_r.sample_in[31], req_r.sample_in}; end
      MP_B0_Y:     begin ma = {b0_r[31], b0_r}; mb = {y_r[31], y_r}; end
      MP_T_DTR:    begin ma = {t_r[31], t_r}; mb = {2'b0, dtr_r}; end
      MP_A1_T:     begin ma = {a1_r[31], a1_r}; mb = {t_r[31], t_r}; end
      MP_ACC_B1R:  begin ma = {acc_r[31], acc_r}; mb = {b1r_r[31], b1r_r}; end
      default:     begin ma = '0; mb = '0; end
    endcase
  end

  // floor shift of the last product, then clip to 32 bits
  assign q_sh  = prod_r >>> FRAC_BITS;
  assign q_ovf = !((&q_sh[PROD_W-1:31]) || !(|q_sh[PROD_W-1:31]));
  assign q_val = !q_ovf ? q_sh[31:0] :
                 (q_sh[PROD_W-1] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}});

  always_comb begin
    unique case (cw.uop)
      UOP_ADDY: sum_res = sat33({y_r[31], y_r} + {q_val[31], q_val});
      UOP_SUBA: sum_res = sat33({t_r[31], t_r} - {q_val[31], q_val});
      UOP_SUBR: sum_res = sat33({req_r.sample_in[31], req_r.sample_in}
                                - {prev_r[31], prev_r});
      UOP_ADDA: sum_res = sat33({acc_r[31], acc_r} + {q_val[31], q_val});
      default:  sum_res = '0;
    endcase
  end

  assign clamp_lo = (y_r < req_r.limit_low) ? req_r.limit_low : y_r;

  always_comb begin
    unique case (cw.br)
      BR_NONE:        br_take = 1'b0;
      BR_ALWAYS:      br_take = 1'b1;
      BR_MODE_LAG:    br_take = (mode_r == MODE_LAG);
      BR_NOT_STARTED: br_take = !started_r;
      default:        br_take = 1'b0;
    endcase
  end

  assign pc_seq = br_take ? cw.tgt : pc_r + 1'b1;

  // previous result still stalled at the output step
  assign out_hold = out_valid_r && out_stall;
  assign out_load = busy_r && (cw.uop == UOP_OUT) && !out_hold;

  always_comb begin
    pc_nxt = pc_seq;
    if (cw.uop == UOP_DISP) begin
      priority if (req_r.op == op_clamp) begin
        pc_nxt = L_CLAMP;
      end else if (mode_r > MODE_LEAD_LAG) begin
        pc_nxt = L_OUT;
      end else if (!started_r) begin
        pc_nxt = L_SLOPE_A;
      end else begin
        pc_nxt = L_INTEG;
      end
    end else if (cw.uop == UOP_OUT && out_hold) begin
      pc_nxt = pc_r;
    end
  end

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LAG;
      a0_r    <= '0;
      a1_r    <= '0;
      b0_r    <= '0;
      b1r_r   <= 32'sd65536;
      dt_r    <= 17'd655;
      dtr_r   <= 31'd6553600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_MODE:     mode_r <= cfg_data[1:0];
        REG_GAIN_ZERO:       a0_r   <= cfg_data;
        REG_GAIN_ONE:        a1_r   <= cfg_data;
        REG_POLE_ZERO:       b0_r   <= cfg_data;
        REG_POLE_ONE_RECIP:  b1r_r  <= cfg_data;
        REG_TIME_STEP:       dt_r   <= cfg_data[16:0];
        REG_TIME_STEP_RECIP: dtr_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= L_DISP;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      y_r         <= '0;
      slope_r     <= '0;
      prev_r      <= '0;
    end else begin
      priority if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (!busy_r) begin
        if (in_valid) begin
          busy_r <= 1'b1;
          pc_r   <= L_DISP;
          req_r  <= in_data;
        end
      end else begin
        pc_r <= pc_nxt;
        unique case (cw.uop)
          UOP_DISP: begin
            sat_r    <= 1'b0;
            show_y_r <= (req_r.op == op_clamp) || (started_r && mode_r <= MODE_LEAD_LAG);
          end
          UOP_MUL:  prod_r <= ma * mb;
          UOP_ADDY: begin y_r <= sum_res.val; sat_r <= sat_r | q_ovf | sum_res.sat; end
          UOP_MOVT: begin t_r <= q_val; sat_r <= sat_r | q_ovf; end
          UOP_SUBA: begin acc_r <= sum_res.val; sat_r <= sat_r | q_ovf | sum_res.sat; end
          UOP_SUBR: begin t_r <= sum_res.val; sat_r <= sat_r | sum_res.sat; end
          UOP_ADDA: begin acc_r <= sum_res.val; sat_r <= sat_r | q_ovf | sum_res.sat; end
          UOP_PREV: prev_r <= req_r.sample_in;
          UOP_SLOPE: begin
            slope_r   <= q_val;
            sat_r     <= sat_r | q_ovf;
            started_r <= 1'b1;
          end
          UOP_CLAMP: y_r <= (clamp_lo > req_r.limit_high) ? req_r.limit_high : clamp_lo;
          UOP_OUT: begin
            // hold here until the previous result has been taken
            if (!out_hold) begin
              out_r.filter_out <= show_y_r ? y_r : '0;
              out_r.saturated  <= sat_r;
              busy_r           <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  `ELLF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, busy_r && pc_r == L_DISP, "request accepted but sequencer not started")
  `ELLF_ASSERT_NEXT(a_unsup_zero, out_load && !show_y_r, out_data.filter_out == 0, "hidden result not zero")
  `ELLF_ASSERT_NOW(a_started_holds, $past(rst_n), !$fell(started_r), "started flag dropped outside reset")
  `ELLF_ASSERT_NEXT(a_clamp_clean, busy_r && cw.uop == UOP_DISP && req_r.op == op_clamp, !sat_r && pc_r == L_CLAMP, "clamp request did not clear saturation")

endmodule

FILE: tb/sv/tb_euler_lead_lag_filter.sv
// Self-checking bench for euler_lead_lag_filter: directed request table, then random phases.
// A Q16.16 lead-lag predictor produces the expected outputs for the checker.
// Depends on ellf_pkg (payload types, register indexes, mode codes) and the RTL top.
module tb_euler_lead_lag_filter;
  import ellf_pkg::*;

  localparam logic       OP_SAMPLE   = 1'b0;
  localparam logic [1:0] MODE_OFF_A  = 2'd2;
  localparam logic [1:0] MODE_OFF_B  = 2'd3;
  localparam int         FRAC        = 16;
  localparam longint     WORD_MAX    = 64'sd2147483647;
  localparam longint     WORD_MIN    = -64'sd2147483648;
  localparam int         MAX_WAIT    = 12;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         CYCLE_LIMIT = 300000;

  typedef struct {
    bit          is_write;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    in_t         req;
    bit          typed;
    out_t        want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of registers and filter state
  logic [1:0] sh_mode = MODE_LAG;
  int         sh_a0 = 0;
  int         sh_a1 = 0;
  int         sh_b0 = 0;
  int         sh_b1r = 32'h0001_0000;
  longint     sh_dt = 655;
  longint     sh_dtr = 6553600;
  int         st_y = 0;
  int         st_slope = 0;
  int         st_prev = 0;
  bit         st_started = 1'b0;
  bit         step_sat;

  out_t      awaited_outputs[$];
  plan_row_t plan[$];
  out_t      head_result;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        send_burst = 1'b0;
  bit        take_burst = 1'b0;
  bit        pending_drain = 1'b0;

  euler_lead_lag_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int sat_word(input longint v);
    if (v > WORD_MAX) begin
      step_sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < WORD_MIN) begin
      step_sat = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic int q_add(input longint a, input longint b);
    return sat_word(a + b);
  endfunction

  function automatic int q_sub(input longint a, input longint b);
    return sat_word(a - b);
  endfunction

  // exact product, floor shift, saturate
  function automatic int q_mul(input longint a, input longint b);
    return sat_word((a * b) >>> FRAC);
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_FILTER_MODE:     sh_mode = data[1:0];
      REG_GAIN_ZERO:       sh_a0 = data;
      REG_GAIN_ONE:        sh_a1 = data;
      REG_POLE_ZERO:       sh_b0 = data;
      REG_POLE_ONE_RECIP:  sh_b1r = data;
      REG_TIME_STEP:       sh_dt = data[16:0];
      REG_TIME_STEP_RECIP: sh_dtr = data[30:0];
      default: ;
    endcase
  endfunction

  function automatic out_t lead_lag_step(input in_t it);
    out_t res;
    int   r;
    int   acc;
    int   rd;
    int   yv;
    step_sat = 1'b0;
    yv = 0;
    if (it.op == op_clamp) begin
      if (st_y < it.limit_low) st_y = it.limit_low;
      if (st_y > it.limit_high) st_y = it.limit_high;
      yv = st_y;
    end else if (sh_mode == MODE_LAG || sh_mode == MODE_LEAD_LAG) begin
      r = it.sample_in;
      rd = 0;
      if (st_started) begin
        st_y = q_add(st_y, q_mul(st_slope, sh_dt));
        yv = st_y;
      end
      acc = q_sub(q_mul(sh_a0, r), q_mul(sh_b0, st_y));
      if (sh_mode == MODE_LEAD_LAG) begin
        // derivative held at zero on the first sample
        if (st_started) rd = q_mul(q_sub(r, st_prev), sh_dtr);
        st_prev = r;
        acc = q_add(acc, q_mul(sh_a1, rd));
      end
      st_slope = q_mul(acc, sh_b1r);
      st_started = 1'b1;
    end
    res.filter_out = yv;
    res.saturated = step_sat;
    return res;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
    plan_row_t row;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t sample_row(input logic [31:0] r, input bit typed,
                                           input logic [31:0] y);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.req.op = OP_SAMPLE;
    row.req.sample_in = r;
    row.req.limit_low = $urandom;
    row.req.limit_high = $urandom;
    row.typed = typed;
    row.want.filter_out = y;
    row.want.saturated = 1'b0;
    return row;
  endfunction

  function automatic plan_row_t clamp_row(input logic [31:0] lo, input logic [31:0] hi,
                                          input bit typed, input logic [31:0] y);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.req.op = op_clamp;
    row.req.sample_in = $urandom;
    row.req.limit_low = lo;
    row.req.limit_high = hi;
    row.typed = typed;
    row.want.filter_out = y;
    row.want.saturated = 1'b0;
    return row;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return pick_extreme();
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef(input int style);
    case (style)
      0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      1: return pick_extreme();
      default: return $urandom;
    endcase
  endfunction

  task automatic drain_outputs();
    while (awaited_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    pending_drain = 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic run_row(input plan_row_t row);
    out_t pred;
    int   gap;
    if (row.is_write) begin
      in_valid <= 1'b0;
      if (pending_drain) drain_outputs();
      cfg_we <= 1'b1;
      cfg_index <= row.reg_idx;
      cfg_data <= row.reg_val;
      @(posedge clk);
      apply_setting(row.reg_idx, row.reg_val);
      @(negedge clk);
    end else begin
      cfg_we <= 1'b0;
      if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data <= row.req;
      do @(posedge clk); while (in_stall);
      pred = lead_lag_step(row.req);
      awaited_outputs.push_back(row.typed ? row.want : pred);
      pending_drain = 1'b1;
      @(negedge clk);
    end
  endtask

  initial begin
    int          style;
    int          n_items;
    logic [1:0]  mode;
    longint      dt;
    logic [31:0] r_walk;
    logic [31:0] mid;
    logic [31:0] span;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // directed table: clamps from reset, unsupported modes, first sample in lead-lag
    plan.push_back(clamp_row(32'd5, 32'd10, 1'b1, 32'd5));
    plan.push_back(clamp_row(32'd100, -32'sd100, 1'b1, -32'sd100));
    plan.push_back(clamp_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, -32'sd100));
    plan.push_back(reg_row(REG_FILTER_MODE, {30'b0, MODE_OFF_A}));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b1, 32'd0));
    plan.push_back(reg_row(REG_FILTER_MODE, {30'b0, MODE_OFF_B}));
    plan.push_back(sample_row(32'h8000_0000, 1'b1, 32'd0));
    plan.push_back(reg_row(REG_FILTER_MODE, {30'b0, MODE_LEAD_LAG}));
    plan.push_back(reg_row(REG_GAIN_ZERO, 32'h0001_0000));
    plan.push_back(reg_row(REG_GAIN_ONE, 32'h0000_8000));
    plan.push_back(reg_row(REG_POLE_ZERO, 32'h0002_0000));
    plan.push_back(reg_row(REG_POLE_ONE_RECIP, 32'h0000_8000));
    plan.push_back(reg_row(REG_TIME_STEP, 32'h0000_1000));
    plan.push_back(reg_row(REG_TIME_STEP_RECIP, 32'h0010_0000));
    plan.push_back(sample_row(32'h0003_0000, 1'b1, 32'd0));
    plan.push_back(sample_row(32'h0003_0000, 1'b0, '0));
    plan.push_back(sample_row(32'hFFFD_8000, 1'b0, '0));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(sample_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(clamp_row(32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000));
    plan.push_back(clamp_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF));
    plan.push_back(sample_row(32'h0000_0000, 1'b0, '0));
    plan.push_back(reg_row(REG_GAIN_ZERO, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_GAIN_ONE, 32'h8000_0000));
    plan.push_back(reg_row(REG_POLE_ZERO, 32'h8000_0000));
    plan.push_back(reg_row(REG_POLE_ONE_RECIP, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_TIME_STEP, 32'h0001_0000));
    plan.push_back(reg_row(REG_TIME_STEP_RECIP, 32'h7FFF_FFFF));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(sample_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(sample_row(32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(clamp_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0));
    plan.push_back(reg_row(REG_FILTER_MODE, {30'b0, MODE_LAG}));
    plan.push_back(reg_row(REG_GAIN_ZERO, 32'h0001_0000));
    plan.push_back(reg_row(REG_GAIN_ONE, 32'h0000_0000));
    plan.push_back(reg_row(REG_POLE_ZERO, 32'h0001_0000));
    plan.push_back(reg_row(REG_POLE_ONE_RECIP, 32'h0001_0000));
    plan.push_back(reg_row(REG_TIME_STEP, 32'd1));
    plan.push_back(reg_row(REG_TIME_STEP_RECIP, 32'd1));
    plan.push_back(sample_row(32'h0001_0000, 1'b0, '0));
    plan.push_back(sample_row(32'h0001_0000, 1'b0, '0));
    plan.push_back(sample_row(32'hFFFF_0000, 1'b0, '0));
    plan.push_back(clamp_row(32'd0, 32'd0, 1'b1, 32'd0));
    plan.push_back(sample_row(32'd1, 1'b0, '0));

    // random phases; style 0 moderate, 1 extremes, 2 anything
    r_walk = 32'h0001_0000;
    for (int ph = 0; ph < 8; ph++) begin
      style = ph % 3;
      if (ph == 5) mode = $urandom_range(0, 1) ? MODE_OFF_B : MODE_OFF_A;
      else mode = (ph % 2) ? MODE_LEAD_LAG : MODE_LAG;
      if (style == 0) dt = $urandom_range(64, 6554);
      else if (style == 1) dt = $urandom_range(0, 1) ? 1 : 65536;
      else dt = $urandom_range(1, 65536);
      plan.push_back(reg_row(REG_FILTER_MODE, {30'b0, mode}));
      plan.push_back(reg_row(REG_GAIN_ZERO, pick_coef(style)));
      plan.push_back(reg_row(REG_GAIN_ONE, pick_coef(style)));
      plan.push_back(reg_row(REG_POLE_ZERO, pick_coef(style)));
      plan.push_back(reg_row(REG_POLE_ONE_RECIP, pick_coef(style)));
      plan.push_back(reg_row(REG_TIME_STEP, 32'(dt)));
      if (style == 0)
        plan.push_back(reg_row(REG_TIME_STEP_RECIP, 32'(64'h1_0000_0000 / dt)));
      else if (style == 1)
        plan.push_back(reg_row(REG_TIME_STEP_RECIP,
                               $urandom_range(0, 1) ? 32'd1 : 32'h7FFF_FFFF));
      else
        plan.push_back(reg_row(REG_TIME_STEP_RECIP, $urandom_range(1, 32'h7FFF_FFFF)));
      n_items = (ph == 5) ? 30 : 100;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          mid = pick_value();
          span = $urandom_range(0, 32'h0004_0000);
          case ($urandom_range(0, 7))
            0: plan.push_back(clamp_row($urandom, $urandom, 1'b0, '0));
            1, 2: plan.push_back(clamp_row(mid + span, mid - span, 1'b0, '0));
            default: plan.push_back(clamp_row(mid - span, mid + span, 1'b0, '0));
          endcase
        end else if ($urandom_range(0, 1)) begin
          // small steps keep the derivative term in range
          r_walk = r_walk + $urandom_range(0, 32'h2000) - 32'h1000;
          plan.push_back(sample_row(r_walk, 1'b0, '0));
        end else begin
          r_walk = pick_value();
          plan.push_back(sample_row(r_walk, 1'b0, '0));
        end
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) run_row(plan[i]);
    in_valid <= 1'b0;
    drain_outputs();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random stall before each accepted output
  initial begin
    int hold;
    out_stall = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      hold = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t: unexpected output filter_out %0d saturated %0b", $time,
                 out_data.filter_out, out_data.saturated);
        mismatch_count++;
      end else begin
        head_result = awaited_outputs.pop_front();
        if (out_data.filter_out !== head_result.filter_out) begin
          $display("%0t: filter_out expected %0d actual %0d", $time,
                   head_result.filter_out, out_data.filter_out);
          mismatch_count++;
        end
        if (out_data.saturated !== head_result.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   head_result.saturated, out_data.saturated);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ellf_pkg.sv
rtl/euler_lead_lag_filter.sv
tb/sv/tb_euler_lead_lag_filter.sv
